@@ design/sird_pkg.sv @@
// Shared types, constants and helpers for the signed-integer-to-radix-digits block.
package sird_pkg;

  localparam int VALUE_W       = 32;
  localparam int SYM_W         = 8;
  localparam int RADIX_W       = 5;
  localparam int ALPHA_N       = 16;
  localparam int ALPHA_IDX_W   = 4;
  localparam int ALPHA_W       = ALPHA_N * SYM_W;
  localparam int HALF_ALPHA_W  = ALPHA_W / 2;
  localparam int MAX_RADIX_DEF = 16;

  // A 32-bit magnitude never needs more than 32 digits (radix 2).
  localparam int DIGITS_MAX    = VALUE_W;
  localparam int STK_IDX_W     = $clog2(DIGITS_MAX);
  localparam int STK_CNT_W     = $clog2(DIGITS_MAX + 1);

  // Divider processes this many dividend bits per cycle.
  localparam int DIV_BITS      = 8;
  localparam int DIV_CYCLES    = VALUE_W / DIV_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;
  localparam int CFG_DATA_W = 64;

  typedef struct packed {
    logic                 start;
    logic [VALUE_W-1:0]   dividend;
    logic [RADIX_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [VALUE_W-1:0]   quotient;
    logic [RADIX_W-1:0]   remainder;
  } div_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [RADIX_W-1:0]   radix;
    logic [ALPHA_W-1:0]   alphabet;
  } chk_req_t;

  typedef struct packed {
    logic                 done;
    logic                 ok;
  } chk_rsp_t;

  typedef struct packed {
    logic                 push;
    logic                 pop;
  } stk_ctl_t;

  function automatic logic [SYM_W-1:0] symbol_at(input logic [ALPHA_W-1:0]     alpha,
                                                 input logic [ALPHA_IDX_W-1:0] idx);
    return alpha[{idx, 3'b000} +: SYM_W];
  endfunction

endpackage

@@ design/sird_in_if.sv @@
// Input channel: one signed value per transfer.
interface sird_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sird_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ design/sird_out_if.sv @@
// Result channel: one text symbol per transfer.
interface sird_out_if;
  logic                        valid;
  logic                        ready;
  logic [sird_pkg::SYM_W-1:0]  symbol;
  logic                        base_error;
  logic                        last;

  modport source (output valid, output symbol, output base_error, output last, input ready);
  modport sink   (input valid, input symbol, input base_error, input last, output ready);
endinterface

@@ design/sird_cfg_if.sv @@
// Configuration write channel: register index and data.
interface sird_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sird_pkg::CFG_IDX_W-1:0]    index;
  logic [sird_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/sird_divider.sv @@
// Iterative restoring divider: 32-bit magnitude by a 5-bit radix, 8 bits per cycle.
module sird_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  sird_pkg::div_req_t req,
  output sird_pkg::div_rsp_t rsp
);

  logic [sird_pkg::VALUE_W-1:0]   work_r, work_nxt;
  logic [sird_pkg::RADIX_W-1:0]   rem_r, rem_nxt;
  logic [sird_pkg::RADIX_W-1:0]   div_r;
  logic [sird_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  // Eight shift-compare-subtract steps; remainder stays below the divisor.
  always_comb begin
    logic [sird_pkg::VALUE_W-1:0] w;
    logic [sird_pkg::RADIX_W-1:0] r;
    w = work_r;
    r = rem_r;
    for (int k = 0; k < sird_pkg::DIV_BITS; k++) begin
      r = {r[sird_pkg::RADIX_W-2:0], w[sird_pkg::VALUE_W-1]};
      w = {w[sird_pkg::VALUE_W-2:0], 1'b0};
      if (r >= div_r) begin
        r    = r - div_r;
        w[0] = 1'b1;
      end
    end
    work_nxt = w;
    rem_nxt  = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        work_r <= req.dividend;
        rem_r  <= '0;
        div_r  <= req.divisor;
        cnt_r  <= '0;
      end else if (busy_r) begin
        work_r <= work_nxt;
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == sird_pkg::DIV_CNT_W'(sird_pkg::DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = work_r;
  assign rsp.remainder = rem_r;

endmodule

@@ design/sird_alpha_check.sv @@
// Alphabet validation: one symbol per cycle against sign bytes and all later symbols.
module sird_alpha_check #(
  parameter int MAX_RADIX = sird_pkg::MAX_RADIX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sird_pkg::chk_req_t req,
  output sird_pkg::chk_rsp_t rsp
);

  logic                             busy_r;
  logic                             done_r;
  logic                             ok_r;
  logic [sird_pkg::ALPHA_IDX_W-1:0] idx_r;
  logic [sird_pkg::SYM_W-1:0]       sym_i;
  logic                             bad;
  logic                             final_i;
  logic                             radix_bad;

  assign radix_bad = (req.radix < sird_pkg::RADIX_W'(2)) ||
                     (req.radix > sird_pkg::RADIX_W'(MAX_RADIX));

  always_comb begin
    sym_i = sird_pkg::symbol_at(req.alphabet, idx_r);
    bad   = (sym_i == sird_pkg::SYM_MINUS) || (sym_i == sird_pkg::SYM_PLUS);
    for (int j = 0; j < sird_pkg::ALPHA_N; j++) begin
      if ((sird_pkg::RADIX_W'(j) > sird_pkg::RADIX_W'(idx_r)) &&
          (sird_pkg::RADIX_W'(j) < req.radix) &&
          (sird_pkg::symbol_at(req.alphabet, sird_pkg::ALPHA_IDX_W'(j)) == sym_i)) begin
        bad = 1'b1;
      end
    end
    final_i = (sird_pkg::RADIX_W'(idx_r) + sird_pkg::RADIX_W'(1)) == req.radix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (radix_bad) begin
          done_r <= 1'b1;
          ok_r   <= 1'b0;
        end else begin
          busy_r <= 1'b1;
          idx_r  <= '0;
        end
      end else if (busy_r) begin
        if (bad) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          ok_r   <= 1'b0;
        end else if (final_i) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          ok_r   <= 1'b1;
        end else begin
          idx_r  <= idx_r + 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.ok   = ok_r;

endmodule

@@ design/sird_digit_stack.sv @@
// Digit stack: digits pushed least significant first, popped most significant first.
module sird_digit_stack #(
  parameter int DW = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sird_pkg::stk_ctl_t             ctl,
  input  logic [DW-1:0]                  push_digit,
  output logic [DW-1:0]                  top_digit,
  output logic [sird_pkg::STK_CNT_W-1:0] count
);

  logic [DW-1:0]                  mem_r [sird_pkg::DIGITS_MAX];
  logic [sird_pkg::STK_CNT_W-1:0] count_r;
  logic [DW-1:0]                  top_r;
  logic [sird_pkg::STK_CNT_W-1:0] below_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.push) begin
      count_r <= count_r + 1'b1;
    end else if (ctl.pop) begin
      count_r <= count_r - 1'b1;
    end
  end

  // Entry just under the top; becomes the top after a pop.
  assign below_pos = count_r - sird_pkg::STK_CNT_W'(2);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[count_r[sird_pkg::STK_IDX_W-1:0]] <= push_digit;
      top_r <= push_digit;
    end else if (ctl.pop) begin
      top_r <= mem_r[below_pos[sird_pkg::STK_IDX_W-1:0]];
    end
  end

  assign top_digit = top_r;
  assign count     = count_r;

endmodule

@@ design/signed_int_to_radix_digits_core.sv @@
// Top level: signed 32-bit value to radix text, with alphabet validation.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    value (signed 32)
//   out_ch   out  valid/ready    symbol (8), base_error, last
//   cfg_ch   in   valid/ready    index (2), data (64); ready always high
//
// One value at a time. Validation walks the alphabet one symbol a cycle,
// and each digit then takes one pass through the shared divider. The
// longest conversion is for radix 2 and the most negative value. Reset is
// synchronous and clears the config registers, sequencer and valid flags.
// A stalled output holds the sequencer; the last symbol waits in the
// output register while the next value is taken in.
module signed_int_to_radix_digits_core #(
  parameter int MAX_RADIX = sird_pkg::MAX_RADIX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sird_in_if.sink     in_ch,
  sird_out_if.source  out_ch,
  sird_cfg_if.sink    cfg_ch
);

  localparam int DW = $clog2(MAX_RADIX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ERR,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Configuration registers
  logic [sird_pkg::RADIX_W-1:0]      radix_r;
  logic [sird_pkg::HALF_ALPHA_W-1:0] alpha_lo_r;
  logic [sird_pkg::HALF_ALPHA_W-1:0] alpha_hi_r;
  logic [sird_pkg::ALPHA_W-1:0]      alphabet;

  // Sequencer
  state_t                       state_r, state_nxt;
  logic                         neg_r, neg_nxt;
  logic [sird_pkg::VALUE_W-1:0] mag_r, mag_nxt;
  logic                         chk_start_r, chk_start_nxt;
  logic                         div_start_r, div_start_nxt;
  logic [sird_pkg::VALUE_W-1:0] in_mag;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [sird_pkg::SYM_W-1:0]   out_sym_r, out_sym_nxt;
  logic                         out_err_r, out_err_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_free;

  sird_pkg::chk_req_t chk_req;
  sird_pkg::chk_rsp_t chk_rsp;
  sird_pkg::div_req_t div_req;
  sird_pkg::div_rsp_t div_rsp;
  sird_pkg::stk_ctl_t stk_ctl;

  logic [DW-1:0]                  top_digit;
  logic [sird_pkg::STK_CNT_W-1:0] stk_count;

  // ---- configuration port ----
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= '0;
      alpha_lo_r <= '0;
      alpha_hi_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sird_pkg::CFG_RADIX:      radix_r    <= cfg_ch.data[sird_pkg::RADIX_W-1:0];
        sird_pkg::CFG_ALPHA_LOW:  alpha_lo_r <= cfg_ch.data;
        sird_pkg::CFG_ALPHA_HIGH: alpha_hi_r <= cfg_ch.data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  assign alphabet = {alpha_hi_r, alpha_lo_r};

  // ---- shared units ----
  assign chk_req.start    = chk_start_r;
  assign chk_req.radix    = radix_r;
  assign chk_req.alphabet = alphabet;

  sird_alpha_check #(.MAX_RADIX(MAX_RADIX)) u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (chk_req),
    .rsp   (chk_rsp)
  );

  assign div_req.start    = div_start_r;
  assign div_req.dividend = mag_r;
  assign div_req.divisor  = radix_r;

  sird_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sird_digit_stack #(.DW(DW)) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (stk_ctl),
    .push_digit (div_rsp.remainder[DW-1:0]),
    .top_digit  (top_digit),
    .count      (stk_count)
  );

  // Magnitude in two's complement; the most negative value maps to 2^31.
  assign in_mag = in_ch.value[sird_pkg::VALUE_W-1] ?
                  (~unsigned'(in_ch.value) + 1'b1) : unsigned'(in_ch.value);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;

  // ---- sequencer ----
  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    chk_start_nxt = 1'b0;
    div_start_nxt = 1'b0;
    stk_ctl.push  = 1'b0;
    stk_ctl.pop   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sym_nxt   = out_sym_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          neg_nxt       = in_ch.value[sird_pkg::VALUE_W-1];
          mag_nxt       = in_mag;
          chk_start_nxt = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_rsp.done) begin
          if (chk_rsp.ok) begin
            div_start_nxt = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            state_nxt     = ST_ERR;
          end
        end
      end
      ST_DIV: begin
        // digits come out least significant first; stack reverses them
        if (div_rsp.done) begin
          stk_ctl.push = 1'b1;
          mag_nxt      = div_rsp.quotient;
          if (div_rsp.quotient != '0) begin
            div_start_nxt = 1'b1;
          end else begin
            state_nxt = neg_r ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = '0;
          out_err_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = sird_pkg::SYM_MINUS;
          out_err_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = sird_pkg::symbol_at(alphabet,
                                              sird_pkg::ALPHA_IDX_W'(top_digit));
          out_err_nxt   = 1'b0;
          out_last_nxt  = (stk_count == sird_pkg::STK_CNT_W'(1));
          stk_ctl.pop   = 1'b1;
          if (stk_count == sird_pkg::STK_CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_start_r <= chk_start_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      mag_r       <= mag_nxt;
      out_sym_r   <= out_sym_nxt;
      out_err_r   <= out_err_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.symbol     = out_sym_r;
  assign out_ch.base_error = out_err_r;
  assign out_ch.last       = out_last_r;

endmodule

@@ tb/tb_top.sv @@
// Testbench for signed_int_to_radix_digits_core: value-to-text conversion checked against a predictor.
module tb_top;
  import sird_pkg::*;

  localparam int MAX_RADIX    = MAX_RADIX_DEF;
  localparam int SETTLE_PAD   = 20;         // idle cycles before a register write
  localparam int END_PAD      = 250;        // beyond the worst conversion time
  localparam int HOLD_OFF     = 400;        // long receiver stall, fills the block
  localparam int RANDOM_SETS  = 8;
  localparam int PER_SET      = 13;
  localparam longint RUN_LIMIT = 4_000_000;

  // One text symbol as the result channel carries it.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             base_error;
    logic             last;
  } text_sym_t;

  logic clk;
  logic rst_n;

  sird_in_if  in_bus ();
  sird_out_if out_bus ();
  sird_cfg_if cfg_bus ();

  signed_int_to_radix_digits_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Values waiting to be offered, and the text we expect back, oldest first.
  logic signed [VALUE_W-1:0] value_backlog[$];
  text_sym_t                 expected_text[$];

  // Our copy of the configuration, updated at each register transfer.
  logic [RADIX_W-1:0] radix_cfg;
  logic [ALPHA_W-1:0] alpha_cfg;

  int send_gap_pct;   // chance per cycle that the sender holds back
  int recv_stall_pct; // chance per cycle that the receiver drops ready
  int hold_cycles;    // remaining cycles of a forced receiver hold-off
  int fail_count;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Symbol idx of the configured alphabet.
  function automatic logic [SYM_W-1:0] alpha_sym(input int idx);
    return alpha_cfg[idx*SYM_W +: SYM_W];
  endfunction

  // Works out the text for one accepted value under the current configuration.
  function automatic void predict_text(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digit_q[$];
    bit                 ok;
    int                 i, j;
    ok = (radix_cfg >= 2) && (radix_cfg <= MAX_RADIX);
    for (i = 0; ok && i < radix_cfg; i++) begin
      if (alpha_sym(i) == SYM_MINUS || alpha_sym(i) == SYM_PLUS) ok = 0;
      for (j = i + 1; j < radix_cfg; j++)
        if (alpha_sym(j) == alpha_sym(i)) ok = 0;
    end
    if (!ok) begin
      // bad alphabet: a lone error symbol, no text
      expected_text.push_back('{8'h00, 1'b1, 1'b1});
      return;
    end
    // two's complement magnitude; the most negative value comes out as 2^31
    mag = v[VALUE_W-1] ? (~v + 32'd1) : v;
    do begin
      digit_q.push_front(4'(mag % radix_cfg));
      mag = mag / radix_cfg;
    end while (mag != 0);
    if (v[VALUE_W-1]) expected_text.push_back('{SYM_MINUS, 1'b0, 1'b0});
    for (i = 0; i < digit_q.size(); i++)
      expected_text.push_back('{alpha_sym(digit_q[i]), 1'b0, (i == digit_q.size() - 1)});
  endfunction

  // Sender: a value stays offered until its transfer, then the next one follows.
  always @(posedge clk) begin : drive_values
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) predict_text(in_bus.value);
      if (!in_bus.valid || in_bus.ready) begin
        if (value_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_bus.valid <= 1'b1;
          in_bus.value <= value_backlog.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: each symbol transfer is checked against the oldest expectation.
  always @(posedge clk) begin : check_text
    text_sym_t want;
    text_sym_t got;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.symbol, out_bus.base_error, out_bus.last};
        if (expected_text.size() == 0) begin
          $display("%0t: symbol with nothing expected: sym %h err %b last %b",
                   $time, got.symbol, got.base_error, got.last);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (got !== want) begin
            $display("%0t: text mismatch: expected sym %h err %b last %b, got sym %h err %b last %b",
                     $time, want.symbol, want.base_error, want.last,
                     got.symbol, got.base_error, got.last);
            fail_count++;
          end
        end
      end
      out_bus.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold-off counter runs on its own; the receiver reads it.
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Returns at a negedge once every value is through and all text has arrived.
  task automatic wait_drained();
    do @(negedge clk);
    while (value_backlog.size() != 0 || in_bus.valid || expected_text.size() != 0);
  endtask

  // Called at a rising edge; returns at the edge of the transfer, valid left high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk);
    while (!cfg_bus.ready);
    case (idx)
      CFG_RADIX:      radix_cfg = d[RADIX_W-1:0];
      CFG_ALPHA_LOW:  alpha_cfg[HALF_ALPHA_W-1:0] = d;
      CFG_ALPHA_HIGH: alpha_cfg[ALPHA_W-1:HALF_ALPHA_W] = d;
      default: ;
    endcase
  endtask

  // Full reconfiguration, only once the block has gone quiet.
  task automatic set_alphabet(input logic [RADIX_W-1:0] r,
                              input logic [CFG_DATA_W-1:0] lo,
                              input logic [CFG_DATA_W-1:0] hi);
    wait_drained();
    repeat (SETTLE_PAD) @(negedge clk);
    @(posedge clk);
    write_reg(CFG_RADIX, CFG_DATA_W'(r));
    write_reg(CFG_ALPHA_LOW, lo);
    write_reg(CFG_ALPHA_HIGH, hi);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_pace(input int gap, input int stall);
    @(negedge clk);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
  endtask

  // Sixteen distinct bytes, none of them a sign character.
  function automatic logic [ALPHA_W-1:0] fresh_alphabet();
    bit                 taken[256];
    logic [ALPHA_W-1:0] a;
    logic [SYM_W-1:0]   b;
    int                 i;
    for (i = 0; i < ALPHA_N; i++) begin
      do b = SYM_W'($urandom);
      while (taken[b] || b == SYM_MINUS || b == SYM_PLUS);
      taken[b] = 1;
      a[i*SYM_W +: SYM_W] = b;
    end
    return a;
  endfunction

  // Mostly well-formed alphabets; about one in five gets broken on purpose.
  task automatic random_setting();
    logic [ALPHA_W-1:0] alpha;
    logic [RADIX_W-1:0] r;
    int                 i, j;
    alpha = fresh_alphabet();
    case ($urandom_range(9))
      0:       r = RADIX_W'(2);
      1:       r = RADIX_W'(MAX_RADIX);
      default: r = RADIX_W'($urandom_range(MAX_RADIX - 1, 3));
    endcase
    if ($urandom_range(4) == 0) begin
      i = $urandom_range(r - 1);
      case ($urandom_range(3))
        0:       r = RADIX_W'($urandom_range(1) ? $urandom_range(1)
                                                : $urandom_range(31, MAX_RADIX + 1));
        1:       alpha[i*SYM_W +: SYM_W] = SYM_MINUS;
        2:       alpha[i*SYM_W +: SYM_W] = SYM_PLUS;
        default: begin
          j = (i + 1 + $urandom_range(r - 2)) % r;
          alpha[j*SYM_W +: SYM_W] = alpha[i*SYM_W +: SYM_W];
        end
      endcase
    end
    set_alphabet(r, alpha[HALF_ALPHA_W-1:0], alpha[ALPHA_W-1:HALF_ALPHA_W]);
  endtask

  // Bias towards the extremes and short texts; the rest is full-range.
  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2:    return $urandom_range(600) - 300;
      default: return $urandom;
    endcase
  endfunction

  initial begin : run_test
    int p;
    in_bus.valid   = 1'b0;
    in_bus.value   = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CFG_RADIX;
    cfg_bus.data   = '0;
    out_bus.ready  = 1'b0;
    radix_cfg      = '0;
    alpha_cfg      = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    fail_count     = 0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: radix 0, so every value gives the error symbol.
    @(negedge clk);
    value_backlog.push_back(32'sd0);
    value_backlog.push_back(-32'sd1);

    // Decimal. The receiver holds off for a long stretch while values keep
    // coming, so the block backs up and stalls its input.
    set_alphabet(5'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938);
    set_pace(0, 0);
    hold_cycles = HOLD_OFF;
    value_backlog.push_back(32'sd0);
    value_backlog.push_back(32'sd1);
    value_backlog.push_back(-32'sd1);
    value_backlog.push_back(32'sd9);
    value_backlog.push_back(32'sd10);
    value_backlog.push_back(-32'sd10);
    value_backlog.push_back(32'sh7FFF_FFFF);
    value_backlog.push_back(32'sh8000_0000);
    value_backlog.push_back(32'sd1234567890);

    // Binary: the most negative value gives the longest text, sign plus 32 digits.
    set_alphabet(5'd2, 64'h0000_0000_0000_3130, 64'h0);
    @(negedge clk);
    value_backlog.push_back(32'sh8000_0000);
    value_backlog.push_back(32'sh7FFF_FFFF);
    value_backlog.push_back(32'sd0);
    value_backlog.push_back(-32'sd1);
    value_backlog.push_back(32'sd5);

    // Radix 16 with a zero byte and an all-ones byte as ordinary symbols.
    set_alphabet(5'd16, 64'h3736_0034_3332_3130, 64'hFF65_6463_6261_3938);
    @(negedge clk);
    value_backlog.push_back(32'sh8000_0000);
    value_backlog.push_back(32'sh7FFF_FFFF);
    value_backlog.push_back(32'sd0);
    value_backlog.push_back(-32'sd1);

    // Invalid alphabets, one value each.
    set_alphabet(5'd1, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938); // radix too small
    @(negedge clk);
    value_backlog.push_back(32'sd7);
    set_alphabet(5'd17, 64'h3736_3534_3332_3130, 64'hFF65_6463_6261_3938); // above the maximum
    @(negedge clk);
    value_backlog.push_back(-32'sd7);
    set_alphabet(5'd31, '1, '1); // all ones everywhere
    @(negedge clk);
    value_backlog.push_back(32'sd100);
    set_alphabet(5'd10, 64'h3736_3534_2D32_3130, 64'h0000_0000_0000_3938); // minus in range
    @(negedge clk);
    value_backlog.push_back(32'sd42);
    set_alphabet(5'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_2B38); // plus in range
    @(negedge clk);
    value_backlog.push_back(-32'sd42);
    set_alphabet(5'd16, 64'h0, 64'h0); // repeated zero bytes
    @(negedge clk);
    value_backlog.push_back(32'sd1);

    // Sign characters and repeats beyond the radix are out of use, so this is valid.
    set_alphabet(5'd3, 64'h0000_2B61_2D63_6261, '1);
    @(negedge clk);
    value_backlog.push_back(-32'sd1);
    value_backlog.push_back(32'sh7FFF_FFFF);

    // Random alphabets and values under each pacing in turn.
    for (p = 0; p < RANDOM_SETS; p++) begin
      random_setting();
      case (p % 4)
        0:       set_pace(0, 0);
        1:       set_pace(60, 0);
        2:       set_pace(0, 60);
        default: set_pace(6, 6);
      endcase
      repeat (PER_SET) value_backlog.push_back(rand_value());
    end

    wait_drained();
    repeat (END_PAD) @(posedge clk);
    if (fail_count == 0) begin
      $display("signed_int_to_radix_digits_core test passed");
    end else begin
      $display("signed_int_to_radix_digits_core test failed");
    end
    $finish;
  end

  // Backstop against a hung handshake.
  initial begin
    #RUN_LIMIT;
    $display("signed_int_to_radix_digits_core test failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/sird_pkg.sv
design/sird_in_if.sv
design/sird_out_if.sv
design/sird_cfg_if.sv
design/sird_divider.sv
design/sird_alpha_check.sv
design/sird_digit_stack.sv
design/signed_int_to_radix_digits_core.sv
tb/tb_top.sv
